[hdl/char_edit_distance_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the edit distance block
// Clocked, reset-gated property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CHAR_EDIT_DISTANCE_TOP_ASSERT_SVH
`define CHAR_EDIT_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication
`define CED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edit distance check failed");

// next-cycle implication
`define CED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edit distance check failed");

`endif

[hdl/ced_pkg.sv]
// ---------------------------------------------------------------------------
// Edit distance package
// Beat types, field widths and command codes.
// ---------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int CH_W        = 21;
    localparam int DIST_W      = 6;
    localparam int DIST_MAX    = 63;

    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    typedef struct packed {
        logic            op;
        logic [CH_W-1:0] ch;
        logic            last;
    } ced_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } ced_out_t;

endpackage

`default_nettype wire

[hdl/ced_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ced_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic                 re,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/char_edit_distance_top.sv]
// Non-last beats and first-word beats are taken while busy stays low.
// The last second-word beat starts the distance run: cost row seeding, cell
// updates (one shared min unit, one cell per read/update pair, none if either
// word is empty) and a one-cycle result strobe; busy is high throughout.
// Reset clears lengths, overflow flag and sequencer; stores need no clearing.
// ---------------------------------------------------------------------------
// Character edit distance
// Loads two words into RAM and runs a row-by-row Levenshtein sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module char_edit_distance_top
    import ced_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ced_in_t  cmd,
    output logic          busy,
    output logic          done,
    output ced_out_t      result
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int OW = (LW > DIST_W) ? LW : DIST_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] fl_reg, fl_next;
    logic [LW-1:0] sl_reg, sl_next;
    logic          trunc_reg, trunc_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] diag_reg, diag_next;

    logic            fw_we, sw_we, fw_re, sw_re, row_we, row_re;
    logic [AW-1:0]   fw_raddr, sw_raddr;
    logic [LW-1:0]   row_waddr, row_raddr, row_wdata;
    logic [CH_W-1:0] fw_rdata, sw_rdata;
    logic [LW-1:0]   row_rdata;

    logic [LW-1:0] im1, jm1;
    logic [LW:0]   cand_up, cand_left, cand_diag, best;
    logic [LW-1:0] cell_new;
    logic [OW-1:0] left_wide;
    logic          accept;

    ced_ram #(.W(CH_W), .D(MAX_LEN)) u_first (
        .clk   (clk),
        .we    (fw_we),
        .waddr (fl_reg[AW-1:0]),
        .wdata (cmd.ch),
        .re    (fw_re),
        .raddr (fw_raddr),
        .rdata (fw_rdata)
    );

    ced_ram #(.W(CH_W), .D(MAX_LEN)) u_second (
        .clk   (clk),
        .we    (sw_we),
        .waddr (sl_reg[AW-1:0]),
        .wdata (cmd.ch),
        .re    (sw_re),
        .raddr (sw_raddr),
        .rdata (sw_rdata)
    );

    ced_ram #(.W(LW), .D(MAX_LEN + 1)) u_row (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    assign accept = start && !busy;
    assign im1    = i_reg - LW'(1);
    assign jm1    = j_reg - LW'(1);

    // shared min unit
    always_comb
    begin
        cand_up   = {1'b0, row_rdata} + (LW+1)'(1);
        cand_left = {1'b0, left_reg} + (LW+1)'(1);
        cand_diag = {1'b0, diag_reg} + (LW+1)'(fw_rdata != sw_rdata);
        best      = (cand_up < cand_left) ? cand_up : cand_left;
        best      = (cand_diag < best) ? cand_diag : best;
        cell_new  = best[LW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        fl_next    = fl_reg;
        sl_next    = sl_reg;
        trunc_next = trunc_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        left_next  = left_reg;
        diag_next  = diag_reg;
        fw_we      = 1'b0;
        sw_we      = 1'b0;
        fw_re      = 1'b0;
        sw_re      = 1'b0;
        row_we     = 1'b0;
        row_re     = 1'b0;
        fw_raddr   = im1[AW-1:0];
        sw_raddr   = jm1[AW-1:0];
        row_raddr  = j_reg;
        row_waddr  = j_reg;
        row_wdata  = j_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_FIRST)
                    begin
                        if (fl_reg != LW'(MAX_LEN))
                        begin
                            fw_we   = 1'b1;
                            fl_next = fl_reg + LW'(1);
                        end
                        else
                        begin
                            trunc_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (sl_reg != LW'(MAX_LEN))
                        begin
                            sw_we   = 1'b1;
                            sl_next = sl_reg + LW'(1);
                        end
                        else
                        begin
                            trunc_next = 1'b1;
                        end
                        if (cmd.last)
                        begin
                            j_next     = '0;
                            state_next = S_INIT;
                        end
                    end
                end
            end
            S_INIT:
            begin
                row_we = 1'b1;
                if (j_reg == sl_reg)
                begin
                    if (fl_reg == '0)
                    begin
                        left_next  = sl_reg;
                        state_next = S_OUT;
                    end
                    else if (sl_reg == '0)
                    begin
                        left_next  = fl_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_next     = LW'(1);
                        j_next     = LW'(1);
                        left_next  = LW'(1);
                        diag_next  = '0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + LW'(1);
                end
            end
            S_RD:
            begin
                sw_re      = 1'b1;
                row_re     = 1'b1;
                fw_re      = (j_reg == LW'(1));
                state_next = S_CMP;
            end
            S_CMP:
            begin
                row_we    = 1'b1;
                row_wdata = cell_new;
                diag_next = row_rdata;
                left_next = cell_new;
                if (j_reg == sl_reg)
                begin
                    if (i_reg == fl_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // next row: cell (i,0) = i, diag starts at (i,0) of previous row
                        i_next     = i_reg + LW'(1);
                        j_next     = LW'(1);
                        left_next  = i_reg + LW'(1);
                        diag_next  = i_reg;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + LW'(1);
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                fl_next    = '0;
                sl_next    = '0;
                trunc_next = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fl_reg    <= '0;
            sl_reg    <= '0;
            trunc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fl_reg    <= fl_next;
            sl_reg    <= sl_next;
            trunc_reg <= trunc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        left_reg <= left_next;
        diag_reg <= diag_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_OUT);
    assign left_wide = OW'(left_reg);

    always_comb
    begin
        result.overflow = trunc_reg;
        if (left_wide > OW'(DIST_MAX))
        begin
            result.distance = DIST_W'(DIST_MAX);
        end
        else
        begin
            result.distance = left_wide[DIST_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/ced_checker.sv]
// ---------------------------------------------------------------------------
// Edit distance port checker
// Watches beats and result strobes on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "char_edit_distance_top_assert.svh"

module ced_checker
    import ced_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire ced_in_t  cmd,
    input wire logic     busy,
    input wire logic     done,
    input wire ced_out_t result
);

    logic beat_first, beat_more, beat_end;

    assign beat_first = start && !busy && (cmd.op == OP_FIRST);
    assign beat_more  = start && !busy && (cmd.op == OP_SECOND) && !cmd.last;
    assign beat_end   = start && !busy && (cmd.op == OP_SECOND) && cmd.last;

    `CED_ASSERT_NOW(a_done_busy, done, busy && (result.distance <= DIST_W'(DIST_MAX)))
    `CED_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
    `CED_ASSERT_NEXT(a_load_free, beat_first || beat_more, !busy && !done)
    `CED_ASSERT_NEXT(a_end_busy, beat_end, busy && !done)

endmodule

bind char_edit_distance_top ced_checker u_ced_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Edit distance block testbench
// Streams word pairs into the block and scores every distance result against
// an in-bench Levenshtein predictor. The pairs mix short words, overlong and
// truncated words, shared-alphabet and full-range code points, and first-word
// beats interleaved with second-word beats. Input gaps come in random bursts.
// ---------------------------------------------------------------------------

module tb_top;
    import ced_pkg::*;

    localparam int MAX_LEN     = MAX_LEN_DEF;
    localparam int ITEM_TARGET = 550;
    localparam int CALM_TAIL   = 80;
    localparam int WDOG_LIMIT  = 12000;
    localparam int SETTLE_CYC  = 64;

    class ed_scoreboard;
        logic [CH_W-1:0] word_a [MAX_LEN];
        logic [CH_W-1:0] word_b [MAX_LEN];
        int unsigned     len_a;
        int unsigned     len_b;
        bit              trunc;
        ced_out_t        expected_q[$];
        int unsigned     errors;
        int unsigned     results_seen;
        int unsigned     overflow_seen;

        function new();
            len_a         = 0;
            len_b         = 0;
            trunc         = 1'b0;
            errors        = 0;
            results_seen  = 0;
            overflow_seen = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function int unsigned edit_distance();
            int unsigned row [MAX_LEN+1];
            int unsigned diag;
            int unsigned up;
            int unsigned sub;
            int unsigned best;
            for (int j = 0; j <= len_b; j++)
                row[j] = j;
            for (int i = 1; i <= len_a; i++)
            begin
                diag   = row[0];
                row[0] = i;
                for (int j = 1; j <= len_b; j++)
                begin
                    up     = row[j];
                    sub    = diag + ((word_a[i-1] != word_b[j-1]) ? 1 : 0);
                    best   = (up + 1 < row[j-1] + 1) ? up + 1 : row[j-1] + 1;
                    row[j] = (best < sub) ? best : sub;
                    diag   = up;
                end
            end
            return (row[len_b] > DIST_MAX) ? DIST_MAX : row[len_b];
        endfunction

        function void note_beat(ced_in_t b);
            ced_out_t exp_r;
            if (b.op == OP_FIRST)
            begin
                if (len_a < MAX_LEN)
                    word_a[len_a++] = b.ch;
                else
                    trunc = 1'b1;
                return;
            end
            if (len_b < MAX_LEN)
                word_b[len_b++] = b.ch;
            else
                trunc = 1'b1;
            if (!b.last)
                return;
            exp_r.distance = DIST_W'(edit_distance());
            exp_r.overflow = trunc;
            expected_q = {expected_q, exp_r};
            if (trunc)
                overflow_seen++;
            len_a = 0;
            len_b = 0;
            trunc = 1'b0;
        endfunction

        task check_result(ced_out_t r);
            ced_out_t exp_r;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with none pending: dist %0d ovf %0b",
                                 r.distance, r.overflow));
                return;
            end
            exp_r = expected_q.pop_front();
            if (r.distance !== exp_r.distance)
                report($sformatf("result %0d distance %0d, expected %0d",
                                 results_seen, r.distance, exp_r.distance));
            if (r.overflow !== exp_r.overflow)
                report($sformatf("result %0d overflow %0b, expected %0b",
                                 results_seen, r.overflow, exp_r.overflow));
        endtask
    endclass

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    ced_in_t  cmd   = '0;
    logic     busy;
    logic     done;
    ced_out_t result;

    ed_scoreboard sb = new();
    int unsigned  beats_sent = 0;
    int unsigned  pairs_sent = 0;
    int unsigned  longest_word = 0;
    int unsigned  gap_rate = 0;
    int unsigned  quiet_cycles = 0;

    always #2 clk = ~clk;

    char_edit_distance_top #(
        .MAX_LEN (MAX_LEN)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic idle_cycles(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // holds the beat until the block takes it; start stays up for the caller
    task automatic send_beat(input ced_in_t b);
        if (beats_sent < ITEM_TARGET - CALM_TAIL && gap_rate != 0 &&
            $urandom_range(0, 99) < gap_rate)
            idle_cycles($urandom_range(1, 13));
        start <= 1'b1;
        cmd   <= b;
        do @(posedge clk); while (busy);
        sb.note_beat(b);
        beats_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_word(input logic op, input string s);
        ced_in_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.op   = op;
            b.ch   = CH_W'(s[i]);
            b.last = (i == s.len() - 1);
            send_beat(b);
        end
    endtask

    function automatic logic [CH_W-1:0] pick_ch(input int mode,
                                                 input logic [CH_W-1:0] base);
        logic [CH_W-1:0] v;
        v = CH_W'($urandom);
        case (mode)
            0: return v;
            1: return base ^ CH_W'($urandom_range(0, 3));
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return CH_W'(21'h10FFFF);
                    default: return v;
                endcase
        endcase
    endfunction

    task automatic run_pair(input int unsigned n1, input int unsigned n2,
                            input int mode, input bit mixed);
        ced_in_t         b;
        logic [CH_W-1:0] base;
        int unsigned     ia;
        int unsigned     ib;
        base = CH_W'($urandom);
        ia   = 0;
        ib   = 0;
        while (ia < n1 || ib + 1 < n2)
        begin
            if (ib + 1 >= n2 || (ia < n1 && (!mixed || $urandom_range(0, 1) == 1)))
            begin
                b.op   = OP_FIRST;
                b.last = (!mixed && ia == n1 - 1) || ($urandom_range(0, 9) == 0);
                ia++;
            end
            else
            begin
                b.op   = OP_SECOND;
                b.last = 1'b0;
                ib++;
            end
            b.ch = pick_ch(mode, base);
            send_beat(b);
        end
        b.op   = OP_SECOND;
        b.ch   = pick_ch(mode, base);
        b.last = 1'b1;
        send_beat(b);
        pairs_sent++;
        if (n1 > longest_word)
            longest_word = n1;
        if (n2 > longest_word)
            longest_word = n2;
    endtask

    function automatic int unsigned pick_len(input int unsigned lo);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
        return $urandom_range(lo, 7);
    endfunction

    initial
    begin
        ced_in_t     b;
        int unsigned n1;
        int unsigned n2;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty first word
        send_word(OP_SECOND, "a");
        // one differing and one matching single-character pair, code point extremes
        b = '{op: OP_FIRST, ch: '0, last: 1'b1};
        send_beat(b);
        b = '{op: OP_SECOND, ch: '1, last: 1'b1};
        send_beat(b);
        b = '{op: OP_FIRST, ch: '1, last: 1'b1};
        send_beat(b);
        b = '{op: OP_SECOND, ch: '1, last: 1'b1};
        send_beat(b);
        // first word keeps growing after its last flag
        b = '{op: OP_FIRST, ch: CH_W'(8'h61), last: 1'b1};
        send_beat(b);
        b = '{op: OP_FIRST, ch: CH_W'(8'h62), last: 1'b0};
        send_beat(b);
        send_word(OP_SECOND, "ab");
        send_word(OP_FIRST, "kitten");
        send_word(OP_SECOND, "sitting");
        pairs_sent += 5;
        wait_drained();

        // overlong words on either side, then two full-length words
        run_pair(MAX_LEN + 2, 3, 0, 1'b0);
        run_pair(3, MAX_LEN + 2, 0, 1'b0);
        run_pair(MAX_LEN, MAX_LEN, 0, 1'b0);
        wait_drained();

        while (beats_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0: gap_rate = 0;
                1: gap_rate = 10;
                2: gap_rate = 30;
                default: gap_rate = 70;
            endcase
            n1 = pick_len(0);
            n2 = pick_len(1);
            run_pair(n1, n2, $urandom_range(0, 5) == 0 ? 0 :
                             ($urandom_range(0, 3) == 0 ? 2 : 1),
                     $urandom_range(0, 5) == 0);
            if (pairs_sent % 12 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        $display("Ran %0d word pairs in %0d beats, longest word %0d characters.",
                 pairs_sent, beats_sent, longest_word);
        $display("Scored %0d distance results, %0d with the overflow flag set.",
                 sb.results_seen, sb.overflow_seen);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ced_pkg.sv
hdl/ced_ram.sv
hdl/char_edit_distance_top.sv
hdl/ced_checker.sv
dv/tb_top.sv
